[hw/rtl/mfr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mfr_pkg;

   // Frame geometry: the start marker is byte 0, the end marker is the last byte.
   localparam int FRAME_BYTES   = 16;
   localparam int PAYLOAD_CELLS = FRAME_BYTES - 2;
   localparam int COUNT_BITS    = $clog2(FRAME_BYTES);

   localparam logic [COUNT_BITS-1:0] LAST_POS = COUNT_BITS'(FRAME_BYTES - 1);
   localparam logic [COUNT_BITS-1:0] FIRST_POS = COUNT_BITS'(1);

   // Configuration register map.
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_MARKER = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_END_MARKER   = CSR_INDEX_BITS'(1);

   localparam logic [7:0] START_MARKER_RESET = 8'd36;
   localparam logic [7:0] END_MARKER_RESET   = 8'd35;

   // Control handed from the frame sequencer to the datapath.
   typedef struct packed {
      logic shift_en;   // Shift the accepted byte into the cell chain.
      logic last_pos;   // The next byte is the last byte of the frame.
      logic complete;   // The accepted byte closes a frame with a good end marker.
   } ctrl_type;

endpackage

`default_nettype wire

[hw/rtl/mfr_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module mfr_cell (
   input  wire logic       clock,
   input  wire logic       shift_en,
   input  wire logic [7:0] data_in,
   output logic      [7:0] data_out
);

   logic [7:0] data_ff;
   logic [7:0] data_in_mux;

   // Take the neighbor's byte whenever the chain advances.
   always_comb begin
      data_in_mux = shift_en ? data_in : data_ff;
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in_mux;
   end

   assign data_out = data_ff;

endmodule

`default_nettype wire

[hw/rtl/mfr_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module mfr_ctrl (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_valid,
   input  wire logic [mfr_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [7:0]                          csr_wdata,
   input  wire logic                                byte_accept,
   input  wire logic [7:0]                          rx_byte,
   output mfr_pkg::ctrl_type                        ctrl
);

   import mfr_pkg::*;

   logic                  in_frame_ff, in_frame_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [7:0]            start_marker_ff, start_marker_in;
   logic [7:0]            end_marker_ff, end_marker_in;
   logic                  at_last;

   // Configuration writes; indexes beyond the map are ignored.
   always_comb begin
      start_marker_in = start_marker_ff;
      end_marker_in   = end_marker_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_START_MARKER: start_marker_in = csr_wdata;
            CSR_END_MARKER:   end_marker_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   assign at_last = in_frame_ff && (count_ff == LAST_POS);

   // Frame sequencer: hunt for the start marker, count payload, check the end.
   always_comb begin
      in_frame_in   = in_frame_ff;
      count_in      = count_ff;
      ctrl.shift_en = 1'b0;
      ctrl.complete = 1'b0;
      ctrl.last_pos = at_last;
      if (byte_accept) begin
         if (!in_frame_ff) begin
            if (rx_byte == start_marker_ff) begin
               in_frame_in = 1'b1;
               count_in    = FIRST_POS;
            end
         end else if (!at_last) begin
            ctrl.shift_en = 1'b1;
            count_in      = count_ff + COUNT_BITS'(1);
         end else begin
            in_frame_in   = 1'b0;
            count_in      = '0;
            ctrl.complete = (rx_byte == end_marker_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff     <= 1'b0;
         count_ff        <= '0;
         start_marker_ff <= START_MARKER_RESET;
         end_marker_ff   <= END_MARKER_RESET;
      end else begin
         in_frame_ff     <= in_frame_in;
         count_ff        <= count_in;
         start_marker_ff <= start_marker_in;
         end_marker_ff   <= end_marker_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/marked_frame_receiver.sv]
// A result is registered and shown on the rsp_ ports in the cycle after the frame's last byte is taken.
// Throughput: one byte per cycle while req_stall is low; the chain of payload cells shifts once per payload byte.
// req_stall rises only on a frame's last byte while the previous result still waits.
// Reset (synchronous, active high) clears the sequencer and rsp_valid and sets the markers to their reset values.
// The payload cells are not reset; a frame always refills them before use.
`timescale 1ns / 1ps
`default_nettype none

module marked_frame_receiver (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Configuration port.
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [mfr_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [7:0]                          csr_wdata,
   // Received bytes.
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [7:0]                          req_rx_byte,
   // Decoded frames.
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic      [31:0]                         rsp_angle_bits,
   output logic      [31:0]                         rsp_temperature_bits,
   output logic      [31:0]                         rsp_speed_bits,
   output logic      [7:0]                          rsp_direction_byte,
   output logic      [7:0]                          rsp_sequence_byte
);

   import mfr_pkg::*;

   ctrl_type   ctrl;
   logic       req_accept;
   logic [7:0] cell_q [PAYLOAD_CELLS];
   logic [7:0] cell_d [PAYLOAD_CELLS];

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] angle_ff, angle_in;
   logic [31:0] temperature_ff, temperature_in;
   logic [31:0] speed_ff, speed_in;
   logic [7:0]  direction_ff, direction_in;
   logic [7:0]  sequence_ff, sequence_in;

   // Configuration writes never wait.
   assign csr_ready = 1'b1;

   // Only the closing byte needs room in the output register.
   assign req_stall  = ctrl.last_pos && rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   mfr_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .byte_accept (req_accept),
      .rx_byte     (req_rx_byte),
      .ctrl        (ctrl)
   );

   // Chain of payload cells: cell 0 takes the new byte, the oldest sits at the far end.
   genvar gi;
   generate
      for (gi = 0; gi < PAYLOAD_CELLS; gi++) begin : g_cell
         if (gi == 0) begin : g_head
            assign cell_d[gi] = req_rx_byte;
         end else begin : g_link
            assign cell_d[gi] = cell_q[gi-1];
         end
         mfr_cell u_cell (
            .clock    (clock),
            .shift_en (ctrl.shift_en),
            .data_in  (cell_d[gi]),
            .data_out (cell_q[gi])
         );
      end
   endgenerate

   // Output register: frame byte n lives in cell PAYLOAD_CELLS - n.
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      angle_in       = angle_ff;
      temperature_in = temperature_ff;
      speed_in       = speed_ff;
      direction_in   = direction_ff;
      sequence_in    = sequence_ff;
      if (ctrl.complete) begin
         rsp_valid_in   = 1'b1;
         angle_in       = {cell_q[10], cell_q[11], cell_q[12], cell_q[13]};
         temperature_in = {cell_q[6], cell_q[7], cell_q[8], cell_q[9]};
         speed_in       = {cell_q[2], cell_q[3], cell_q[4], cell_q[5]};
         direction_in   = cell_q[1];
         sequence_in    = cell_q[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      angle_ff       <= angle_in;
      temperature_ff <= temperature_in;
      speed_ff       <= speed_in;
      direction_ff   <= direction_in;
      sequence_ff    <= sequence_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_angle_bits       = angle_ff;
   assign rsp_temperature_bits = temperature_ff;
   assign rsp_speed_bits       = speed_ff;
   assign rsp_direction_byte   = direction_ff;
   assign rsp_sequence_byte    = sequence_ff;

endmodule

`default_nettype wire

[hw/rtl/mfr_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module mfr_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [31:0] rsp_angle_bits,
   input wire logic [7:0]  rsp_sequence_byte
);

   // A stalled result transaction stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // A stalled result keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_angle_bits) && $stable(rsp_sequence_byte))
      else $error("result payload changed while stalled");

   // Reset leaves no result pending.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

   // A fresh result needs an input transaction in the cycle before.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || !rsp_stall) |=> !rsp_valid || $past(req_valid && !req_stall))
      else $error("result appeared without an input transaction");

endmodule

bind marked_frame_receiver mfr_checker u_mfr_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_angle_bits    (rsp_angle_bits),
   .rsp_sequence_byte (rsp_sequence_byte)
);

`default_nettype wire

[test/mfr_frame_checker.sv]
`timescale 1ns / 1ps

// Watches the three channels of the marked frame receiver. It keeps its own copy of the
// marker registers and of the frame being collected, predicts each decoded frame, and
// compares every result transaction with the oldest prediction.
module mfr_frame_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_valid,
   input  wire logic                                csr_ready,
   input  wire logic [mfr_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [7:0]                          csr_wdata,
   input  wire logic                                req_valid,
   input  wire logic                                req_stall,
   input  wire logic [7:0]                          req_rx_byte,
   input  wire logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   input  wire logic [31:0]                         rsp_angle_bits,
   input  wire logic [31:0]                         rsp_temperature_bits,
   input  wire logic [31:0]                         rsp_speed_bits,
   input  wire logic [7:0]                          rsp_direction_byte,
   input  wire logic [7:0]                          rsp_sequence_byte,
   output int                                       frames_pending,
   output int                                       mismatches
);

   import mfr_pkg::*;

   typedef struct packed {
      logic [31:0] angle_bits;
      logic [31:0] temperature_bits;
      logic [31:0] speed_bits;
      logic [7:0]  direction_byte;
      logic [7:0]  sequence_byte;
   } decoded_frame_type;

   // Shadow of the marker registers and of the deframer state.
   logic [7:0]            open_marker;
   logic [7:0]            close_marker;
   logic                  collecting;
   logic [COUNT_BITS-1:0] cell_pos;
   logic [7:0]            rx_cells [FRAME_BYTES];

   // Decoded frames that are still owed by the block, oldest first.
   decoded_frame_type frames_due [$];

   // Feeds one received byte through the deframer. Returns 1 when the byte closes a frame
   // with a good end marker, and then the decoded frame is in frame.
   function automatic bit absorb_byte(input logic [7:0] rx, output decoded_frame_type frame);
      frame = '0;
      // While idle only the start marker matters; it becomes byte 0.
      if (!collecting) begin
         if (rx == open_marker) begin
            rx_cells[0] = rx;
            cell_pos    = FIRST_POS;
            collecting  = 1'b1;
         end
         return 1'b0;
      end
      // Inside a frame every byte is data, markers included.
      rx_cells[cell_pos] = rx;
      if (cell_pos != LAST_POS) begin
         cell_pos = cell_pos + 1'b1;
         return 1'b0;
      end
      // The last byte either delivers the frame or drops it; either way back to idle.
      collecting = 1'b0;
      cell_pos   = '0;
      if (rx != close_marker) begin
         return 1'b0;
      end
      frame.angle_bits       = {rx_cells[4], rx_cells[3], rx_cells[2], rx_cells[1]};
      frame.temperature_bits = {rx_cells[8], rx_cells[7], rx_cells[6], rx_cells[5]};
      frame.speed_bits       = {rx_cells[12], rx_cells[11], rx_cells[10], rx_cells[9]};
      frame.direction_byte   = rx_cells[13];
      frame.sequence_byte    = rx_cells[14];
      return 1'b1;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      decoded_frame_type predicted;
      if (reset) begin
         open_marker  = START_MARKER_RESET;
         close_marker = END_MARKER_RESET;
         collecting   = 1'b0;
         cell_pos     = '0;
         frames_due.delete();
      end else begin
         // Register writes; indexes outside the map are ignored.
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_START_MARKER) begin
               open_marker = csr_wdata;
            end else if (csr_index == CSR_END_MARKER) begin
               close_marker = csr_wdata;
            end
         end
         // Accepted byte transaction.
         if (req_valid && !req_stall) begin
            if (absorb_byte(req_rx_byte, predicted)) begin
               frames_due.push_back(predicted);
            end
         end
         // Accepted result transaction.
         if (rsp_valid && !rsp_stall) begin
            if (frames_due.size() == 0) begin
               $error("unexpected frame: angle %h, temperature %h, speed %h",
                      rsp_angle_bits, rsp_temperature_bits, rsp_speed_bits);
               mismatches++;
            end else begin
               predicted = frames_due.pop_front();
               check_field("angle_bits", predicted.angle_bits, rsp_angle_bits);
               check_field("temperature_bits", predicted.temperature_bits,
                           rsp_temperature_bits);
               check_field("speed_bits", predicted.speed_bits, rsp_speed_bits);
               check_field("direction_byte", 32'(predicted.direction_byte),
                           32'(rsp_direction_byte));
               check_field("sequence_byte", 32'(predicted.sequence_byte),
                           32'(rsp_sequence_byte));
            end
         end
      end
      frames_pending = frames_due.size();
   end

endmodule

[test/tb_marked_frame_receiver.sv]
`timescale 1ns / 1ps

module tb_marked_frame_receiver;
   import mfr_pkg::*;

   localparam int ITEM_TARGET   = 1550;
   localparam int PHASE_ITEMS   = 220;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 8;

   // Indexes past the register map; writes there must change nothing.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNMAPPED_LO = CSR_INDEX_BITS'(2);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNMAPPED_HI = CSR_INDEX_BITS'(3);

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [7:0]                csr_wdata = '0;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [7:0]                req_rx_byte = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [31:0]               rsp_angle_bits;
   logic [31:0]               rsp_temperature_bits;
   logic [31:0]               rsp_speed_bits;
   logic [7:0]                rsp_direction_byte;
   logic [7:0]                rsp_sequence_byte;

   int         frames_pending;
   int         mismatches;
   int         cycle_count = 0;
   int         framed_items = 0;
   int         rsp_hold = 0;
   bit         calm = 1'b0;
   logic [7:0] start_now;
   logic [7:0] end_now;

   marked_frame_receiver DUT (
      .clock                (clock),
      .reset                (reset),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_rx_byte          (req_rx_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_angle_bits       (rsp_angle_bits),
      .rsp_temperature_bits (rsp_temperature_bits),
      .rsp_speed_bits       (rsp_speed_bits),
      .rsp_direction_byte   (rsp_direction_byte),
      .rsp_sequence_byte    (rsp_sequence_byte)
   );

   mfr_frame_checker watcher (
      .clock                (clock),
      .reset                (reset),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_rx_byte          (req_rx_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_angle_bits       (rsp_angle_bits),
      .rsp_temperature_bits (rsp_temperature_bits),
      .rsp_speed_bits       (rsp_speed_bits),
      .rsp_direction_byte   (rsp_direction_byte),
      .rsp_sequence_byte    (rsp_sequence_byte),
      .frames_pending       (frames_pending),
      .mismatches           (mismatches)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_marked_frame_receiver NOT OK");
         $finish;
      end
   end

   // Result side back-pressure: short bursts of stall, now and then a long one.
   always @(negedge clock) begin
      int r;
      if (calm) begin
         rsp_stall <= 1'b0;
         rsp_hold  <= 0;
      end else if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            rsp_stall <= 1'b0;
            rsp_hold  <= $urandom_range(0, 6);
         end else if (r < 95) begin
            rsp_stall <= 1'b1;
            rsp_hold  <= $urandom_range(0, 2);
         end else begin
            rsp_stall <= 1'b1;
            rsp_hold  <= $urandom_range(8, 40);
         end
      end
   end

   // Idle cycles before the next byte: mostly none, some short, a few long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 70) begin
         return 0;
      end
      if (r < 95) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   // Payload content, leaning on the marker values now and then.
   function automatic logic [7:0] payload_byte();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         return start_now;
      end
      if (r < 15) begin
         return end_now;
      end
      return 8'($urandom);
   endfunction

   // Called at a falling edge; returns at the falling edge after the transaction.
   task automatic send_byte(input logic [7:0] rx);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= rx;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Start marker, body_len payload bytes, then an end byte when the frame is full length.
   task automatic send_frame(input int body_len, input bit good_end);
      logic [7:0] last;
      send_byte(start_now);
      for (int i = 0; i < body_len; i++) begin
         send_byte(payload_byte());
      end
      framed_items += body_len + 1;
      if (body_len == FRAME_BYTES - 2) begin
         last = good_end ? end_now : 8'($urandom);
         send_byte(last);
         framed_items++;
      end
   endtask

   // Holds the byte channel off until every owed frame has come out.
   task automatic drain();
      req_valid <= 1'b0;
      while (frames_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Bytes that can never open a frame; enough of them to close any frame in flight.
   task automatic close_phase();
      logic [7:0] filler;
      for (int i = 0; i < FRAME_BYTES; i++) begin
         do filler = 8'($urandom); while (filler == start_now);
         send_byte(filler);
      end
      drain();
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index, input logic [7:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_markers(input logic [7:0] open_value, input logic [7:0] close_value);
      write_csr(CSR_START_MARKER, open_value);
      write_csr(CSR_END_MARKER, close_value);
      write_csr($urandom_range(0, 1) ? CSR_UNMAPPED_HI : CSR_UNMAPPED_LO, 8'($urandom));
      start_now = open_value;
      end_now   = close_value;
      @(negedge clock);
   endtask

   initial begin
      logic [7:0] sample_frame [FRAME_BYTES] = '{
         8'd36, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00,
         8'h00, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'd36, 8'hA5, 8'd35};
      logic [7:0] open_table [5]  = '{8'd0, 8'd255, 8'h5A, 8'd36, 8'h0F};
      logic [7:0] close_table [5] = '{8'd255, 8'd0, 8'h5A, 8'd35, 8'hF0};
      int phase;
      int phase_stop;
      int r;

      repeat (10) @(negedge clock);
      reset     <= 1'b0;
      start_now = START_MARKER_RESET;
      end_now   = END_MARKER_RESET;
      @(negedge clock);

      // Directed: bytes that idle ignores, then one frame with extreme payload values and
      // a start marker sitting inside the payload.
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(END_MARKER_RESET);
      foreach (sample_frame[i]) begin
         send_byte(sample_frame[i]);
      end
      framed_items += FRAME_BYTES;
      drain();

      // Random phases, each under its own marker setting.
      phase = 0;
      while (framed_items < ITEM_TARGET) begin
         if (phase < 5) begin
            set_markers(open_table[phase], close_table[phase]);
         end else begin
            set_markers(8'($urandom), 8'($urandom));
         end
         calm <= ($urandom_range(0, 3) == 0);
         phase_stop = framed_items + PHASE_ITEMS;
         while (framed_items < phase_stop) begin
            if ($urandom_range(0, 49) == 0) begin
               drain();
            end
            r = $urandom_range(0, 99);
            if (r < 70) begin
               send_frame(FRAME_BYTES - 2, 1'b1);
            end else if (r < 82) begin
               send_frame(FRAME_BYTES - 2, 1'b0);
            end else if (r < 92) begin
               // Noise between frames; a stray start marker will misalign what follows.
               repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            end else begin
               // Frame cut short; the next start marker lands inside it as data.
               send_frame($urandom_range(1, FRAME_BYTES - 3), 1'b0);
            end
            if ($urandom_range(0, 19) == 0) begin
               calm <= !calm;
            end
         end
         close_phase();
         phase++;
      end

      if (mismatches == 0) begin
         $display("tb_marked_frame_receiver OK");
      end else begin
         $display("tb_marked_frame_receiver NOT OK");
      end
      $finish;
   end

endmodule
